### sv/pkpw_pkg.sv
// Package for the per-key priority waitlist.
// Holds request and status codes, the chain operation type and default sizes.
// No dependencies.
package pkpw_pkg;
  localparam int NumResourcesDef = 16;
  localparam int QueueDepthDef = 16;
  localparam int IdBitsDef = 16;

  typedef enum logic [2:0] {
    REQ_ENQ = 3'd0,
    REQ_SERVE = 3'd1,
    REQ_RETURN = 3'd2,
    REQ_CANCEL = 3'd3,
    REQ_LOAD = 3'd4
  } req_t;

  typedef enum logic [2:0] {
    ST_OK = 3'd0,
    ST_FULL = 3'd1,
    ST_NO_STOCK = 3'd2,
    ST_EMPTY = 3'd3,
    ST_NOT_LENT = 3'd4,
    ST_NOT_FOUND = 3'd5
  } status_t;

  // Operation applied to every cell of the chain together.
  typedef struct packed {
    logic       ins;
    logic       del;
    logic [6:0] pos;
  } chain_op_t;
endpackage

### sv/pkpw_cell.sv
// One cell of the queue chain: holds one queue slot of one resource.
// Loads a row value, takes the new entry at the insert position, or takes a neighbor's value on insert or remove.
// Depends on pkpw_pkg.
module pkpw_cell #(
  parameter int W = 18,
  parameter int POS = 0
) (
  input  logic              clk,
  input  logic              ld_en,
  input  logic [W-1:0]      ld_val,
  input  pkpw_pkg::chain_op_t op,
  input  logic [W-1:0]      new_val,
  input  logic [W-1:0]      prev_val,
  input  logic [W-1:0]      next_val,
  output logic [W-1:0]      val
);
  logic [W-1:0] val_r;
  logic [W-1:0] val_nxt;

  always_comb begin
    val_nxt = val_r;
    if (ld_en) begin
      val_nxt = ld_val;
    end else if (op.ins) begin
      if (7'(POS) == op.pos) val_nxt = new_val;
      else if (7'(POS) > op.pos) val_nxt = prev_val;
    end else if (op.del) begin
      if (7'(POS) >= op.pos) val_nxt = next_val;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign val = val_r;
endmodule

### sv/per_key_priority_waitlist.sv
// Per-key priority waitlist: top level with chain, memory and control.
// out_valid rises after the request has passed through READ, SCAN, SHIFT and DONE; busy stays high
// through those states, so a new request is accepted only once the block is back in IDLE.
// Each request loads a row of the queue memory into the cell chain, scans it, applies one shift
// step across the chain, then writes the row back.
// Synchronous active-low reset clears counters and control; queue memory is not cleared.
// Depends on pkpw_pkg and pkpw_cell. The receiver cannot stall results.
module per_key_priority_waitlist #(
  parameter int NUM_RESOURCES = pkpw_pkg::NumResourcesDef,
  parameter int QUEUE_DEPTH = pkpw_pkg::QueueDepthDef,
  parameter int ID_BITS = pkpw_pkg::IdBitsDef
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_req_type,
  input  logic [3:0]  in_resource_index,
  input  logic [15:0] in_member_id,
  input  logic [1:0]  in_member_priority,
  input  logic [7:0]  in_stock_value,
  output logic        out_valid,
  output logic [2:0]  out_status,
  output logic [15:0] out_granted_id,
  output logic [1:0]  out_granted_priority,
  output logic [4:0]  out_queue_length
);
  localparam int RB = (NUM_RESOURCES > 1) ? $clog2(NUM_RESOURCES) : 1;
  localparam int CB = $clog2(QUEUE_DEPTH + 1);
  localparam int EW = ID_BITS + 2;
  localparam int RW = EW * QUEUE_DEPTH;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_READ = 5'b00010,
    S_SCAN = 5'b00100,
    S_SHIFT = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  logic [RW-1:0] mem [NUM_RESOURCES];
  logic [RW-1:0] rd_r;
  logic [CB-1:0] qcnt_r [NUM_RESOURCES];
  logic [7:0] stock_r [NUM_RESOURCES];
  logic [7:0] lent_r [NUM_RESOURCES];
  logic [2:0] type_r;
  logic [RB-1:0] res_r;
  logic [ID_BITS-1:0] id_r;
  logic [1:0] prio_r;
  logic [7:0] sv_r;
  pkpw_pkg::chain_op_t op_r, op_nxt;
  logic [2:0] st_r, st_nxt;
  logic [ID_BITS-1:0] gid_r, gid_nxt;
  logic [1:0] gpr_r, gpr_nxt;
  logic valid_r;
  logic [RW-1:0] row;
  logic [EW-1:0] vals [QUEUE_DEPTH];
  logic [CB-1:0] n;
  logic [CB-1:0] ins_p, del_p;
  logic del_hit;
  logic [RB-1:0] res_in;
  logic [RB-1:0] res_map [16];

  genvar m;
  generate
    for (m = 0; m < 16; m++) begin : g_res
      assign res_map[m] = RB'(m % NUM_RESOURCES);
    end
  endgenerate

  assign res_in = res_map[in_resource_index];
  assign n = qcnt_r[res_r];

  genvar g;
  generate
    for (g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
      logic [EW-1:0] pv, nv;
      if (g == 0) begin : g_f
        assign pv = '0;
      end else begin : g_p
        assign pv = vals[g-1];
      end
      if (g == QUEUE_DEPTH - 1) begin : g_l
        assign nv = '0;
      end else begin : g_n
        assign nv = vals[g+1];
      end
      pkpw_cell #(.W(EW), .POS(g)) u_cell (
        .clk(clk), .ld_en(state_r == S_READ), .ld_val(rd_r[g*EW +: EW]),
        .op((state_r == S_SHIFT) ? op_r : '0), .new_val({id_r, prio_r}),
        .prev_val(pv), .next_val(nv), .val(vals[g]));
      assign row[g*EW +: EW] = vals[g];
    end
  endgenerate

  always_comb begin
    ins_p = CB'(n);
    for (int k = QUEUE_DEPTH - 1; k >= 0; k--) begin
      if (CB'(k) < n && vals[k][1:0] < prio_r) ins_p = CB'(k);
    end
    del_hit = 1'b0;
    del_p = '0;
    for (int k = QUEUE_DEPTH - 1; k >= 0; k--) begin
      if (CB'(k) < n && vals[k][EW-1:2] == id_r) begin
        del_hit = 1'b1;
        del_p = CB'(k);
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    op_nxt = op_r;
    st_nxt = st_r;
    gid_nxt = gid_r;
    gpr_nxt = gpr_r;
    case (state_r)
      S_IDLE: if (start) state_nxt = S_READ;
      S_READ: state_nxt = S_SCAN;
      S_SCAN: begin
        op_nxt = '0;
        st_nxt = pkpw_pkg::ST_OK;
        gid_nxt = '0;
        gpr_nxt = '0;
        case (type_r)
          pkpw_pkg::REQ_ENQ: begin
            if (n >= CB'(QUEUE_DEPTH)) st_nxt = pkpw_pkg::ST_FULL;
            else begin
              op_nxt.ins = 1'b1;
              op_nxt.pos = 7'(ins_p);
            end
          end
          pkpw_pkg::REQ_SERVE: begin
            if (lent_r[res_r] >= stock_r[res_r]) st_nxt = pkpw_pkg::ST_NO_STOCK;
            else if (n == '0) st_nxt = pkpw_pkg::ST_EMPTY;
            else begin
              op_nxt.del = 1'b1;
              gid_nxt = vals[0][EW-1:2];
              gpr_nxt = vals[0][1:0];
            end
          end
          pkpw_pkg::REQ_RETURN: begin
            if (lent_r[res_r] == '0) st_nxt = pkpw_pkg::ST_NOT_LENT;
          end
          pkpw_pkg::REQ_CANCEL: begin
            if (!del_hit) st_nxt = pkpw_pkg::ST_NOT_FOUND;
            else begin
              op_nxt.del = 1'b1;
              op_nxt.pos = 7'(del_p);
            end
          end
          default: ;
        endcase
        state_nxt = S_SHIFT;
      end
      S_SHIFT: state_nxt = S_DONE;
      S_DONE: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      valid_r <= 1'b0;
      op_r <= '0;
      for (int i = 0; i < NUM_RESOURCES; i++) begin
        qcnt_r[i] <= '0;
        stock_r[i] <= '0;
        lent_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      op_r <= op_nxt;
      valid_r <= (state_r == S_DONE);
      if (state_r == S_SHIFT) begin
        if (op_r.ins) qcnt_r[res_r] <= n + 1'b1;
        if (op_r.del) qcnt_r[res_r] <= n - 1'b1;
        if (type_r == pkpw_pkg::REQ_SERVE && op_r.del) lent_r[res_r] <= lent_r[res_r] + 8'd1;
        if (type_r == pkpw_pkg::REQ_RETURN && st_r == pkpw_pkg::ST_OK)
          lent_r[res_r] <= lent_r[res_r] - 8'd1;
        if (type_r == pkpw_pkg::REQ_LOAD) stock_r[res_r] <= sv_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    st_r <= st_nxt;
    gid_r <= gid_nxt;
    gpr_r <= gpr_nxt;
    if (state_r == S_IDLE && start) begin
      type_r <= in_req_type;
      res_r <= res_in;
      id_r <= ID_BITS'(in_member_id);
      prio_r <= in_member_priority;
      sv_r <= in_stock_value;
      rd_r <= mem[res_in];
    end
    if (state_r == S_DONE) mem[res_r] <= row;
  end

  assign busy = (state_r != S_IDLE);
  assign out_valid = valid_r;
  assign out_status = st_r;
  assign out_granted_id = 16'(gid_r);
  assign out_granted_priority = gpr_r;
  assign out_queue_length = 5'(qcnt_r[res_r]);

  a_one_op: assert property (@(posedge clk) disable iff (!rst_n) !(op_r.ins && op_r.del))
    else $error("insert and remove at once");
  a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SHIFT) |-> n <= CB'(QUEUE_DEPTH))
    else $error("queue count over depth");
  a_valid: assert property (@(posedge clk) disable iff (!rst_n) out_valid |-> !busy)
    else $error("result while busy");
  a_lat: assert property (@(posedge clk) disable iff (!rst_n) (start && !busy) |=> ##3 valid_r == 1'b0 ##1 out_valid)
    else $error("latency broken");
endmodule
